### sv/nfc_tlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NFC TLV parser package
// Type codes, status codes, parser phase codes and the result record.
// ----------------------------------------------------------------------------
package nfc_tlv_pkg;

  // TLV type bytes
  localparam logic [7:0] TLV_NULL = 8'h00;
  localparam logic [7:0] TLV_LOCK = 8'h01;
  localparam logic [7:0] TLV_MEM  = 8'h02;
  localparam logic [7:0] TLV_NDEF = 8'h03;
  localparam logic [7:0] TLV_PROP = 8'hFD;
  localparam logic [7:0] TLV_TERM = 8'hFE;

  // escape byte announcing a three-byte length field
  localparam logic [7:0] LEN_ESC      = 8'hFF;
  localparam logic [7:0] CTRL_TLV_LEN = 8'd3;

  // header sizes in bytes
  localparam logic [2:0] HDR_SHORT = 3'd2;
  localparam logic [2:0] HDR_LONG  = 3'd4;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FORMAT    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // parser phases
  localparam logic [2:0] PH_TYPE     = 3'd0;
  localparam logic [2:0] PH_CTRL_LEN = 3'd1;
  localparam logic [2:0] PH_LEN1     = 3'd2;
  localparam logic [2:0] PH_LEN_HI   = 3'd3;
  localparam logic [2:0] PH_LEN_LO   = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tlv_type;
    logic [15:0] tlv_length;
    logic [15:0] tlv_offset;
    logic [15:0] value_offset;
    logic [16:0] tlv_size;
  } tlv_res_t;

endpackage
`default_nettype wire

### sv/nfc_tlv_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NFC TLV stream parser
// Walks a tag data area one byte per transaction and reports each TLV header,
// unknown types, format errors and truncated buffers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in_     | input     | in_valid/in_stall   | data_byte, restart, last_byte
//  out_    | output    | out_valid/out_stall | status, tlv_type, tlv_length,
//          |           |                     | tlv_offset, value_offset, tlv_size
//
//  One byte per cycle while in_stall is low. Parser state is updated at
//  the acceptance edge; the result lands in a two-entry output buffer
//  (output register plus skid register), in the skid register while the
//  output register is held. in_stall rises only when both entries are
//  full, so input keeps flowing while the skid register is free.
//  rst_n is synchronous, active low, and returns the parser to offset zero.
//
module nfc_tlv_stream_parser
  import nfc_tlv_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_restart,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_tlv_type,
  output logic [15:0]      out_tlv_length,
  output logic [15:0]      out_tlv_offset,
  output logic [15:0]      out_value_offset,
  output logic [16:0]      out_tlv_size
);

  // parser state
  logic [2:0]             phase_r, phase_nxt;
  logic [7:0]             ctype_r, ctype_nxt;
  logic [7:0]             len_hi_r, len_hi_nxt;
  logic [15:0]            vrem_r, vrem_nxt;
  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   halted_r, halted_nxt;

  // output buffer
  logic     out_valid_r, skid_valid_r;
  tlv_res_t out_data_r, skid_data_r;

  logic     accept, pop;
  logic     res_fire;
  tlv_res_t res;

  logic [2:0]             eff_phase;
  logic [7:0]             eff_ctype;
  logic [15:0]            eff_vrem;
  logic [OFFSET_BITS-1:0] eff_start;
  logic                   eff_halted;
  logic [OFFSET_BITS-1:0] pos, pos_inc;
  logic [31:0]            pos_w, pos_inc_w, start_w;
  logic [15:0]            vrem_dec;
  logic                   hd_fire;
  logic [15:0]            hd_len;
  logic [2:0]             hd_hdr;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    // a restart byte drops everything and sits at offset zero
    eff_phase  = in_restart ? PH_TYPE : phase_r;
    eff_ctype  = in_restart ? '0 : ctype_r;
    eff_vrem   = in_restart ? '0 : vrem_r;
    eff_start  = in_restart ? '0 : start_r;
    eff_halted = in_restart ? 1'b0 : halted_r;
    pos        = in_restart ? '0 : byte_offset_r;
    pos_inc    = pos + OFFSET_BITS'(1);
    pos_w      = 32'(pos);
    pos_inc_w  = 32'(pos_inc);
    vrem_dec   = eff_vrem - 16'd1;

    phase_nxt       = eff_phase;
    ctype_nxt       = eff_ctype;
    vrem_nxt        = eff_vrem;
    start_nxt       = eff_start;
    halted_nxt      = eff_halted;
    len_hi_nxt      = in_restart ? '0 : len_hi_r;
    byte_offset_nxt = pos_inc;

    res_fire = 1'b0;
    res      = '0;
    hd_fire  = 1'b0;
    hd_len   = '0;
    hd_hdr   = '0;

    if (!eff_halted) begin
      unique case (eff_phase)
        PH_TYPE: begin
          start_nxt = pos;
          ctype_nxt = in_data_byte;
          unique case (in_data_byte) inside
            TLV_NULL, TLV_TERM: begin
              res_fire         = 1'b1;
              res.status       = ST_OK;
              res.tlv_type     = in_data_byte;
              res.tlv_offset   = pos_w[15:0];
              res.value_offset = pos_inc_w[15:0];
              res.tlv_size     = 17'd1;
              if (in_data_byte == TLV_TERM) begin
                halted_nxt = 1'b1;
              end
            end
            TLV_LOCK, TLV_MEM: begin
              phase_nxt = PH_CTRL_LEN;
            end
            TLV_NDEF, TLV_PROP: begin
              phase_nxt = PH_LEN1;
            end
            default: begin
              res_fire       = 1'b1;
              res.status     = ST_NOT_FOUND;
              res.tlv_type   = in_data_byte;
              res.tlv_offset = pos_w[15:0];
              res.tlv_size   = 17'd1;
            end
          endcase
        end
        PH_CTRL_LEN: begin
          if (in_data_byte != CTRL_TLV_LEN) begin
            start_w        = 32'(eff_start);
            res_fire       = 1'b1;
            res.status     = ST_FORMAT;
            res.tlv_type   = eff_ctype;
            res.tlv_offset = start_w[15:0];
            phase_nxt      = PH_TYPE;
            halted_nxt     = 1'b1;
          end else begin
            hd_fire = 1'b1;
            hd_len  = 16'(CTRL_TLV_LEN);
            hd_hdr  = HDR_SHORT;
          end
        end
        PH_LEN1: begin
          if (in_data_byte == LEN_ESC) begin
            phase_nxt = PH_LEN_HI;
          end else begin
            hd_fire = 1'b1;
            hd_len  = 16'(in_data_byte);
            hd_hdr  = HDR_SHORT;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = in_data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          hd_fire = 1'b1;
          hd_len  = {len_hi_r, in_data_byte};
          hd_hdr  = HDR_LONG;
        end
        PH_SKIP: begin
          vrem_nxt = vrem_dec;
          if (vrem_dec == 16'd0) begin
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase

      if (hd_fire) begin
        start_w          = 32'(eff_start);
        res_fire         = 1'b1;
        res.status       = ST_OK;
        res.tlv_type     = eff_ctype;
        res.tlv_length   = hd_len;
        res.tlv_offset   = start_w[15:0];
        res.value_offset = pos_inc_w[15:0];
        res.tlv_size     = 17'(hd_hdr) + 17'(hd_len);
        vrem_nxt         = hd_len;
        phase_nxt        = (hd_len != 16'd0) ? PH_SKIP : PH_TYPE;
      end

      // end of buffer: a header or value still open is reported as truncated, unless this byte already gave a result
      if (in_last_byte) begin
        if (!res_fire && phase_nxt != PH_TYPE) begin
          start_w        = 32'(start_nxt);
          res_fire       = 1'b1;
          res            = '0;
          res.status     = ST_TRUNC;
          res.tlv_type   = ctype_nxt;
          res.tlv_offset = start_w[15:0];
        end
        phase_nxt = PH_TYPE;
        vrem_nxt  = '0;
      end
    end
    start_w = 32'(start_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TYPE;
      ctype_r       <= '0;
      len_hi_r      <= '0;
      vrem_r        <= '0;
      byte_offset_r <= '0;
      start_r       <= '0;
      halted_r      <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      ctype_r       <= ctype_nxt;
      len_hi_r      <= len_hi_nxt;
      vrem_r        <= vrem_nxt;
      byte_offset_r <= byte_offset_nxt;
      start_r       <= start_nxt;
      halted_r      <= halted_nxt;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept && res_fire) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept && res_fire) begin
      if (!out_valid_r || pop) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_data_r.status;
  assign out_tlv_type     = out_data_r.tlv_type;
  assign out_tlv_length   = out_data_r.tlv_length;
  assign out_tlv_offset   = out_data_r.tlv_offset;
  assign out_value_offset = out_data_r.value_offset;
  assign out_tlv_size     = out_data_r.tlv_size;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_halt_in_type: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (phase_r == PH_TYPE))
    else $error("parser halted outside the type phase");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (vrem_r != 16'd0))
    else $error("value skip armed with zero count");

  a_notfound_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_NOT_FOUND) |->
      (out_data_r.tlv_size == 17'd1 && out_data_r.tlv_length == 16'd0))
    else $error("unknown type result with wrong size");

  a_buffer_order: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output register");
`endif

endmodule
`default_nettype wire
